// File: design/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types, register map and helpers of the stepper dose sequencer.
// ----------------------------------------------------------------------------
package sds_pkg;

   localparam int DOSE_W  = 13;
   localparam int SAMPLE_W = 12;
   localparam int SPC_W   = 4;
   localparam int ML_W    = 7;
   localparam int COIL_W  = 4;
   localparam int PHASE_W = 2;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 32;

   localparam logic [DOSE_W-1:0] DOSE_MIN_RESET = DOSE_W'(10);
   localparam logic [DOSE_W-1:0] DOSE_MAX_RESET = DOSE_W'(8000);
   localparam logic [SPC_W-1:0]  SPC_RESET      = SPC_W'(3);

   // 65535 = 85 * 771, so (x + 1) * 771 >> 16 gives x / 85 exactly for x < 8192
   localparam int ML_RECIP = 771;
   localparam int ML_SHIFT = 16;
   localparam int ML_PROD_W = DOSE_W + 1 + 10;

   typedef enum logic [1:0] {
      REG_DOSE_MIN        = 2'd0,
      REG_DOSE_MAX        = 2'd1,
      REG_STEPS_PER_COUNT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [DOSE_W-1:0] dose_min;
      logic [DOSE_W-1:0] dose_max;
      logic [SPC_W-1:0]  steps_per_count;
   } cfg_type;

   typedef struct packed {
      logic                start_pressed;
      logic                stop_pressed;
      logic                sample_valid;
      logic [SAMPLE_W-1:0] adc_sample;
   } req_item_type;

   typedef struct packed {
      logic [COIL_W-1:0] coil_pattern;
      logic              bridge_enable;
      logic              run_led;
      logic              stop_led;
      logic [DOSE_W-1:0] remaining;
      logic [ML_W-1:0]   display_ml;
   } rsp_item_type;

   // Full-step coil drive, bits in4..in1
   function automatic logic [COIL_W-1:0] coil_lookup(input logic [PHASE_W-1:0] phase);
      logic [COIL_W-1:0] pat;
      case (phase)
         2'd0:    pat = 4'd5;
         2'd1:    pat = 4'd9;
         2'd2:    pat = 4'd10;
         2'd3:    pat = 4'd6;
         default: pat = 4'd0;
      endcase
      return pat;
   endfunction

   function automatic logic [ML_W-1:0] dose_to_ml(input logic [DOSE_W-1:0] dose);
      logic [ML_PROD_W-1:0] prod;
      prod = ML_PROD_W'({1'b0, dose} + (DOSE_W+1)'(1)) * ML_PROD_W'(ML_RECIP);
      return prod[ML_SHIFT +: ML_W];
   endfunction

endpackage

// File: design/sds_csr.sv
// ----------------------------------------------------------------------------
// sds_csr
// APB register bank holding dose clamp limits and steps per dose count.
// ----------------------------------------------------------------------------
module sds_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sds_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [sds_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [sds_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   output sds_pkg::cfg_type             cfg
);

   sds_pkg::cfg_type       cfg_ff, cfg_in;
   sds_pkg::reg_index_type reg_index;
   logic                   write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = sds_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            sds_pkg::REG_DOSE_MIN:
               cfg_in.dose_min = csr_pwdata[sds_pkg::DOSE_W-1:0];
            sds_pkg::REG_DOSE_MAX:
               cfg_in.dose_max = csr_pwdata[sds_pkg::DOSE_W-1:0];
            sds_pkg::REG_STEPS_PER_COUNT:
               cfg_in.steps_per_count = csr_pwdata[sds_pkg::SPC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         sds_pkg::REG_DOSE_MIN:
            csr_prdata = sds_pkg::DATA_W'(cfg_ff.dose_min);
         sds_pkg::REG_DOSE_MAX:
            csr_prdata = sds_pkg::DATA_W'(cfg_ff.dose_max);
         sds_pkg::REG_STEPS_PER_COUNT:
            csr_prdata = sds_pkg::DATA_W'(cfg_ff.steps_per_count);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dose_min        <= sds_pkg::DOSE_MIN_RESET;
         cfg_ff.dose_max        <= sds_pkg::DOSE_MAX_RESET;
         cfg_ff.steps_per_count <= sds_pkg::SPC_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/sds_core.sv
// ----------------------------------------------------------------------------
// sds_core
// Sequencer state (mode, dose, substep, phase) and the per-tick update.
// ----------------------------------------------------------------------------
module sds_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  commit,
   input  sds_pkg::req_item_type item,
   input  sds_pkg::cfg_type      cfg,
   output sds_pkg::rsp_item_type result
);

   logic                          running_ff, running_in;
   logic [sds_pkg::DOSE_W-1:0]    dose_ff, dose_in;
   logic [sds_pkg::SPC_W-1:0]     substep_ff, substep_in;
   logic [sds_pkg::PHASE_W-1:0]   phase_ff, phase_in;

   logic                          run_mode;
   logic [sds_pkg::SPC_W-1:0]     sub_base;
   logic [sds_pkg::SPC_W-1:0]     sub_inc;
   logic [sds_pkg::DOSE_W-1:0]    dose_pick;
   logic [sds_pkg::DOSE_W-1:0]    dose_lo;
   logic [sds_pkg::DOSE_W-1:0]    dose_new;

   always_comb begin
      // start first, then stop
      run_mode = item.start_pressed ? 1'b1 : running_ff;
      sub_base = item.start_pressed ? '0 : substep_ff;
      if (item.stop_pressed) begin
         run_mode = 1'b0;
      end

      dose_pick = item.sample_valid ? {item.adc_sample, 1'b0} : dose_ff;
      dose_lo   = (dose_pick <= cfg.dose_min) ? cfg.dose_min : dose_pick;
      sub_inc   = sub_base + sds_pkg::SPC_W'(1);

      running_in = run_mode;
      substep_in = sub_base;
      phase_in   = phase_ff;
      dose_new   = dose_ff;
      result     = '0;

      if (!run_mode) begin
         result.stop_led = 1'b1;
         dose_new = (dose_lo >= cfg.dose_max) ? cfg.dose_max : dose_lo;
      end else begin
         result.run_led       = 1'b1;
         result.bridge_enable = 1'b1;
         result.coil_pattern  = sds_pkg::coil_lookup(phase_ff);
         substep_in = sub_inc;
         if (sub_inc == cfg.steps_per_count) begin
            substep_in = '0;
            // saturate at zero
            if (dose_ff != '0) begin
               dose_new = dose_ff - sds_pkg::DOSE_W'(1);
            end
         end
         if (dose_new == '0) begin
            running_in = 1'b0;
         end
         phase_in = phase_ff + sds_pkg::PHASE_W'(1);
      end

      dose_in           = dose_new;
      result.remaining  = dose_new;
      result.display_ml = sds_pkg::dose_to_ml(dose_new);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         dose_ff    <= '0;
         substep_ff <= '0;
         phase_ff   <= '0;
      end else if (commit) begin
         running_ff <= running_in;
         dose_ff    <= dose_in;
         substep_ff <= substep_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

// File: design/stepper_dose_sequencer_top.sv
// Path: a tick accepted into the input register reaches rsp_* via the result register.
// Throughput: one tick per cycle; the input register refills in the cycle it
//   hands its tick to the result register, so only a stalled result backs up.
// Reset: idle mode, dose 0, substep 0, first coil phase; registers return to
//   dose_min 10, dose_max 8000, steps_per_count 3; both stages empty.
// ----------------------------------------------------------------------------
// stepper_dose_sequencer_top
// Two-phase full-step stepper sequencer for a dosing pump, with APB setup.
// ----------------------------------------------------------------------------
module stepper_dose_sequencer_top (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: start_pressed[0], stop_pressed[1], sample_valid[2],
   //            adc_sample[14:3], unused [15]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sds_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // rsp_tdata: coil_pattern[3:0], bridge_enable[4], run_led[5], stop_led[6],
   //            remaining[19:7], display_ml[26:20], zero [31:27]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sds_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sds_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [sds_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [sds_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   sds_pkg::cfg_type      cfg;
   sds_pkg::req_item_type req_item;
   sds_pkg::req_item_type in_item_ff, in_item_in;
   sds_pkg::rsp_item_type core_result;
   sds_pkg::rsp_item_type out_item_ff, out_item_in;
   logic                  in_valid_ff, in_valid_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  req_take;
   logic                  advance;

   assign req_item.start_pressed = req_tdata[0];
   assign req_item.stop_pressed  = req_tdata[1];
   assign req_item.sample_valid  = req_tdata[2];
   assign req_item.adc_sample    = req_tdata[14:3];

   sds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sds_core u_core (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // move the held tick into the result register when that slot frees up
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in   = req_take ? req_item : in_item_ff;
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_item_in  = advance ? core_result : out_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0,
                        out_item_ff.display_ml,
                        out_item_ff.remaining,
                        out_item_ff.stop_led,
                        out_item_ff.run_led,
                        out_item_ff.bridge_enable,
                        out_item_ff.coil_pattern};

   // exactly one mode LED per result
   a_led_onehot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_item_ff.run_led != out_item_ff.stop_led))
      else $error("run and stop LED not exclusive");

   // bridge and coils follow run mode
   a_idle_coils_off: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.stop_led) |->
         (out_item_ff.coil_pattern == '0 && !out_item_ff.bridge_enable))
      else $error("coils driven in idle mode");

   a_run_bridge_on: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.run_led) |->
         (out_item_ff.bridge_enable && $countones(out_item_ff.coil_pattern) == 2))
      else $error("step pattern missing in run mode");

   // display value is remaining / 85
   a_display_ml: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |->
         ((14'(out_item_ff.display_ml) * 14'd85 <= 14'(out_item_ff.remaining)) &&
          (14'(out_item_ff.remaining) < 14'(out_item_ff.display_ml) * 14'd85 + 14'd85)))
      else $error("display_ml does not match remaining");

   // a tick in the input stage moves on once the result slot is free
   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("input stage stalled with free result register");

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stepper dose sequencer. Control ticks stream in
// with random gaps; each result is checked field by field against an in-bench
// model of the pump. Register writes happen between phases with the streams
// drained, and the receiver stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT       = 2000;
   localparam int HOLD_CYCLES      = 300;
   localparam int ML_PER_COUNT     = 85;
   localparam int RANDOM_PER_PHASE = 140;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [sds_pkg::REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [sds_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [sds_pkg::ADDR_W-1:0]      csr_paddr   = '0;
   logic [sds_pkg::DATA_W-1:0]      csr_pwdata  = '0;
   logic [sds_pkg::DATA_W-1:0]      csr_prdata;
   logic                            csr_pready;

   // Pump model: registers and state
   logic [sds_pkg::DOSE_W-1:0]  dose_min_cfg  = sds_pkg::DOSE_MIN_RESET;
   logic [sds_pkg::DOSE_W-1:0]  dose_max_cfg  = sds_pkg::DOSE_MAX_RESET;
   logic [sds_pkg::SPC_W-1:0]   spc_cfg       = sds_pkg::SPC_RESET;
   logic                        pump_running  = 1'b0;
   logic [sds_pkg::DOSE_W-1:0]  dose_left     = '0;
   logic [sds_pkg::SPC_W-1:0]   substep_count = '0;
   logic [sds_pkg::PHASE_W-1:0] coil_phase    = '0;

   sds_pkg::req_item_type ticks_to_send[$];
   sds_pkg::rsp_item_type pump_outputs_due[$];
   sds_pkg::req_item_type tick_on_bus;
   int           ticks_queued  = 0;
   int           ticks_checked = 0;
   int           gap_left      = 0;
   int           stall_left    = 0;
   int           hold_left     = 0;
   logic         hold_rsp_req  = 1'b0;
   logic         hold_seen     = 1'b0;
   logic         no_idle       = 1'b0;
   int           failures      = 0;
   int           idle_cycles   = 0;

   stepper_dose_sequencer_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // start[0], stop[1], sample_valid[2], adc_sample[14:3]
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // coil[3:0], bridge[4], run_led[5], stop_led[6],
                                  // remaining[19:7], display_ml[26:20]
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 5);
   endfunction

   // Advance the pump by one control tick and return what it drives
   function automatic sds_pkg::rsp_item_type pump_tick(sds_pkg::req_item_type t);
      sds_pkg::rsp_item_type o;
      o = '0;
      if (t.start_pressed) begin
         pump_running  = 1'b1;
         substep_count = '0;
      end
      if (t.stop_pressed) pump_running = 1'b0;
      if (!pump_running) begin
         o.stop_led = 1'b1;
         if (t.sample_valid) dose_left = {t.adc_sample, 1'b0};
         // lower clamp first, so crossed limits end at dose_max
         if (dose_left <= dose_min_cfg) dose_left = dose_min_cfg;
         if (dose_left >= dose_max_cfg) dose_left = dose_max_cfg;
      end else begin
         o.run_led       = 1'b1;
         o.bridge_enable = 1'b1;
         substep_count   = substep_count + 1'b1;
         if (substep_count == spc_cfg) begin
            if (dose_left != '0) dose_left = dose_left - 1'b1;
            substep_count = '0;
         end
         if (dose_left == '0) pump_running = 1'b0;
         case (coil_phase)
            2'd0:    o.coil_pattern = 4'd5;
            2'd1:    o.coil_pattern = 4'd9;
            2'd2:    o.coil_pattern = 4'd10;
            default: o.coil_pattern = 4'd6;
         endcase
         coil_phase = coil_phase + 1'b1;
      end
      o.remaining  = dose_left;
      o.display_ml = sds_pkg::ML_W'(dose_left / ML_PER_COUNT);
      return o;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic push_tick(int start, int stop, int valid, int sample);
      sds_pkg::req_item_type t;
      t.start_pressed = (start != 0);
      t.stop_pressed  = (stop != 0);
      t.sample_valid  = (valid != 0);
      t.adc_sample    = sds_pkg::SAMPLE_W'(sample);
      ticks_to_send.push_back(t);
      ticks_queued++;
   endtask

   task automatic write_pump_reg(sds_pkg::reg_index_type idx, int value);
      logic [sds_pkg::DATA_W-1:0] keep;
      keep = (idx == sds_pkg::REG_STEPS_PER_COUNT) ? (1 << sds_pkg::SPC_W) - 1
                                                   : (1 << sds_pkg::DOSE_W) - 1;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= sds_pkg::ADDR_W'({idx, 2'b00});
      // unused upper bits carry noise
      csr_pwdata  <= (sds_pkg::DATA_W'($urandom) & ~keep) |
                     (sds_pkg::DATA_W'(value) & keep);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         sds_pkg::REG_DOSE_MIN:        dose_min_cfg = sds_pkg::DOSE_W'(value);
         sds_pkg::REG_DOSE_MAX:        dose_max_cfg = sds_pkg::DOSE_W'(value);
         sds_pkg::REG_STEPS_PER_COUNT: spc_cfg      = sds_pkg::SPC_W'(value);
         default: ;
      endcase
   endtask

   task automatic write_limits(int dmin, int dmax, int spc);
      write_pump_reg(sds_pkg::REG_DOSE_MIN, dmin);
      write_pump_reg(sds_pkg::REG_DOSE_MAX, dmax);
      write_pump_reg(sds_pkg::REG_STEPS_PER_COUNT, spc);
   endtask

   // hold until every queued tick has come back and been checked
   task automatic wait_pump_idle();
      do @(posedge clock);
      while (ticks_checked != ticks_queued);
      repeat (3) @(posedge clock);
   endtask

   // Mostly complete dose cycles: set a dose while idle, start, run; rest noise
   task automatic queue_random_doses(int count);
      int                           first;
      int                           n;
      logic [sds_pkg::SAMPLE_W-1:0] s;
      first = ticks_queued;
      while (ticks_queued - first < count) begin
         if ($urandom_range(0, 9) < 7) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               // keep most doses short so runs use them up
               s = ($urandom_range(0, 9) < 6) ? sds_pkg::SAMPLE_W'($urandom_range(0, 15))
                                               : sds_pkg::SAMPLE_W'($urandom);
               push_tick(0, 0, $urandom_range(0, 3) != 0, s);
            end
            push_tick(1, 0, $urandom_range(0, 1), $urandom);
            n = $urandom_range(3, 40);
            repeat (n)
               push_tick($urandom_range(0, 19) == 0, $urandom_range(0, 29) == 0,
                         $urandom_range(0, 1), $urandom);
         end else begin
            n = $urandom_range(1, 8);
            repeat (n)
               push_tick($urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom);
         end
      end
   endtask

   // Tick sender
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) pump_outputs_due.push_back(pump_tick(tick_on_bus));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (ticks_to_send.size() != 0) begin
               tick_on_bus = ticks_to_send.pop_front();
               req_tdata  <= {1'b0, tick_on_bus.adc_sample, tick_on_bus.sample_valid,
                              tick_on_bus.stop_pressed, tick_on_bus.start_pressed};
               req_tvalid <= 1'b1;
               gap_left    = draw_wait();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result receiver and checker
   always @(posedge clock) begin : rsp_side
      sds_pkg::rsp_item_type want;
      logic                  took;
      logic                  next_ready;
      took = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            took = 1'b1;
            if (pump_outputs_due.size() == 0) begin
               $error("rsp transaction with no tick outstanding: tdata %h", rsp_tdata);
               failures++;
            end else begin
               want = pump_outputs_due.pop_front();
               check_field("coil_pattern", want.coil_pattern, rsp_tdata[3:0]);
               check_field("bridge_enable", want.bridge_enable, rsp_tdata[4]);
               check_field("run_led", want.run_led, rsp_tdata[5]);
               check_field("stop_led", want.stop_led, rsp_tdata[6]);
               check_field("remaining", want.remaining, rsp_tdata[19:7]);
               check_field("display_ml", want.display_ml, rsp_tdata[26:20]);
               ticks_checked++;
            end
         end
         if (hold_rsp_req != hold_seen) begin
            hold_seen = hold_rsp_req;
            hold_left = HOLD_CYCLES;
         end
         if (took) stall_left = draw_wait();
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_tready <= next_ready;
      end
   end

   // Watchdog: no transaction on either stream for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset limits: clamping, both buttons, a short run
      push_tick(0, 0, 0, 0);          // no sample: held dose still clamped
      push_tick(0, 0, 1, 0);
      push_tick(0, 0, 1, 12'hFFF);    // doubled sample above dose_max
      push_tick(0, 0, 1, 5);          // lands exactly on dose_min
      push_tick(1, 1, 1, 12'hAAA);    // stop wins over start
      push_tick(0, 0, 1, 12);
      push_tick(1, 0, 0, 0);
      repeat (2) push_tick(0, 0, 1, 12'h555);
      push_tick(0, 1, 0, 0);
      wait_pump_idle();

      // Zero dose in run mode, then the last count used up
      write_limits(0, 13'h1FFF, 1);
      push_tick(0, 0, 1, 0);
      push_tick(1, 0, 0, 0);
      push_tick(0, 0, 0, 0);
      push_tick(0, 0, 1, 1);
      push_tick(1, 0, 0, 0);
      repeat (2) push_tick(0, 0, 0, 0);
      wait_pump_idle();

      // Crossed limits
      write_limits(13'h1FFF, 0, 15);
      push_tick(0, 0, 0, 0);
      push_tick(0, 0, 1, 12'hFFF);
      wait_pump_idle();

      // Leave substep above a smaller count, then let it wrap
      write_pump_reg(sds_pkg::REG_DOSE_MIN, 0);
      write_pump_reg(sds_pkg::REG_DOSE_MAX, 13'h1FFF);
      push_tick(0, 0, 1, 100);
      push_tick(1, 0, 0, 0);
      repeat (9) push_tick(0, 0, 0, 0);
      wait_pump_idle();
      write_pump_reg(sds_pkg::REG_STEPS_PER_COUNT, 0);
      repeat (7) push_tick(0, 0, 0, 0);
      push_tick(0, 1, 0, 0);
      wait_pump_idle();

      write_limits($urandom_range(0, 40), $urandom_range(2000, 8191), $urandom_range(1, 15));
      queue_random_doses(RANDOM_PER_PHASE);
      wait_pump_idle();

      // Hold off the receiver while ticks keep coming
      write_limits(0, 13'h1FFF, 1);
      queue_random_doses(RANDOM_PER_PHASE);
      hold_rsp_req <= ~hold_rsp_req;
      wait_pump_idle();

      write_limits(13'h1FFF, 0, 15);
      queue_random_doses(RANDOM_PER_PHASE);
      wait_pump_idle();

      no_idle <= 1'b1;
      write_limits(0, 0, 0);
      queue_random_doses(RANDOM_PER_PHASE);
      wait_pump_idle();
      no_idle <= 1'b0;

      write_limits($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 15));
      queue_random_doses(RANDOM_PER_PHASE);
      wait_pump_idle();

      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
